@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at each clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

@@ hdl/owsp_pkg.sv @@
// Package with types and constants of the omni wheel speed to period block
`timescale 1ns / 1ps
package owsp_pkg;
   localparam int CORDIC_STEPS = 14;
   localparam int WHEELS = 4;
   localparam int HEADING_STEPS = 512;
   localparam logic signed [18:0] CORDIC_GAIN = 19'sd39797;
   localparam logic signed [31:0] COEF_Y = 32'sd6832903;
   localparam logic signed [31:0] COEF_X = 32'sd8453524;
   // angular coefficient split as COEF_W_HI * 2^20 + COEF_W_LO
   localparam logic signed [31:0] COEF_W_HI = 32'sd958312;
   localparam logic signed [31:0] COEF_W_LO = 32'sd353369;
   localparam logic [27:0] PERIOD_NUM = 28'd178721715;
   localparam logic [27:0] PERIOD_MAX = 28'd1000000;

   typedef struct packed {
      logic [11:0] speed;
      logic [8:0]  heading;
      logic [11:0] angular;
      logic        sense;
   } cmd_type;

   typedef struct packed {
      logic signed [20:0] p4;
      logic signed [20:0] p3;
      logic signed [20:0] p2;
      logic signed [20:0] p1;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CORDIC, ST_PROD, ST_MUL, ST_LIMIT, ST_DIV, ST_NEXT, ST_OUT
   } state_type;

   function automatic logic [13:0] turn_atan(input logic [3:0] i);
      case (i)
         4'd0: turn_atan = 14'd8192;
         4'd1: turn_atan = 14'd4836;
         4'd2: turn_atan = 14'd2555;
         4'd3: turn_atan = 14'd1297;
         4'd4: turn_atan = 14'd651;
         4'd5: turn_atan = 14'd326;
         4'd6: turn_atan = 14'd163;
         4'd7: turn_atan = 14'd81;
         4'd8: turn_atan = 14'd41;
         4'd9: turn_atan = 14'd20;
         4'd10: turn_atan = 14'd10;
         4'd11: turn_atan = 14'd5;
         4'd12: turn_atan = 14'd3;
         4'd13: turn_atan = 14'd1;
         default: turn_atan = 14'd0;
      endcase
   endfunction
endpackage

@@ hdl/omni_wheel_speed_to_period.sv @@
// Top level of the omni wheel speed to period block
// Usage:
//   req_ carries one drive command per beat; tdata holds speed_mm_s,
//   heading, angular_speed and rotation_sense from the lowest bit up.
//   rsp_ returns the four signed wheel period counts of that command.
//   csr_ writes accel_step (index 0) and slow_ramp_limit (index 1).
// Steps from a request beat to its result beat: the queue, the CORDIC
//   rotation, the products on the shared multiplier, then per wheel the
//   sum, the limit, a 28-step restoring division and the store, and
//   last the result is presented.
// The engine takes a new command only after its result has been taken;
//   the divider serves the four wheels in turn.
// A two-beat queue takes commands while the engine works.
// Reset empties the queue, clears the stored wheel speeds and restores
//   the registers to their defaults.
// When rsp_tready is low the result holds and the engine waits; the
//   queue keeps taking commands until it is full.
`timescale 1ns / 1ps
module omni_wheel_speed_to_period (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // speed_mm_s, heading, angular_speed, rotation_sense
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,  // period_wheel_one..period_wheel_four
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [19:0] csr_wdata
);
   import owsp_pkg::*;
   logic [15:0] accel_ff;
   logic [19:0] limit_ff;
   logic        f_valid, f_ready, e_valid, e_ready;
   cmd_type     f_cmd, e_cmd;
   result_type  res;

   owsp_front u_front (
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata[33:0]),
      .q_valid(f_valid), .q_ready(f_ready), .q_data(f_cmd));

   owsp_queue u_queue (
      .clock(clock), .reset(reset), .in_valid(f_valid), .in_ready(f_ready),
      .in_data(f_cmd), .out_valid(e_valid), .out_ready(e_ready), .out_data(e_cmd));

   owsp_engine u_engine (
      .clock(clock), .reset(reset), .accel_step(accel_ff), .slow_ramp_limit(limit_ff),
      .cmd_valid(e_valid), .cmd_ready(e_ready), .cmd(e_cmd),
      .phase(16'(32'(e_cmd.heading) * (65536 / HEADING_STEPS))),
      .res_valid(rsp_tvalid), .res_ready(rsp_tready), .res(res));

   assign rsp_tdata = {4'd0, res};

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff <= 16'd4096;
         limit_ff <= 20'd61440;
      end else if (csr_we) begin
         if (csr_index == 1'b0) accel_ff <= csr_wdata[15:0];
         else limit_ff <= csr_wdata;
      end
   end
endmodule

@@ hdl/owsp_queue.sv @@
// Two-entry command queue between the front end and the compute engine
`timescale 1ns / 1ps
module owsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  owsp_pkg::cmd_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output owsp_pkg::cmd_type out_data
);
   import owsp_pkg::*;
   cmd_type    mem_ff [2];
   logic       wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;
   assign wp_in  = push ? ~wp_ff : wp_ff;
   assign rp_in  = pop ? ~rp_ff : rp_ff;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end
endmodule

@@ hdl/owsp_front.sv @@
// Front end: accept a command beat and reduce the heading to the step count
`timescale 1ns / 1ps
module owsp_front (
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [33:0]       req_tdata,
   output logic              q_valid,
   input  logic              q_ready,
   output owsp_pkg::cmd_type q_data
);
   import owsp_pkg::*;

   assign q_valid    = req_tvalid;
   assign req_tready = q_ready;
   assign q_data     = '{speed: req_tdata[11:0],
                        heading: 9'(32'(req_tdata[20:12]) % HEADING_STEPS),
                        angular: req_tdata[32:21], sense: req_tdata[33]};
endmodule

@@ hdl/owsp_engine.sv @@
// Compute engine: CORDIC, wheel sums, ramp limit and period division
`timescale 1ns / 1ps
module owsp_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [15:0]          accel_step,
   input  logic [19:0]          slow_ramp_limit,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   input  owsp_pkg::cmd_type    cmd,
   input  logic [15:0]          phase,
   output logic                 res_valid,
   input  logic                 res_ready,
   output owsp_pkg::result_type res
);
   import owsp_pkg::*;
   state_type state_ff, state_in;
   logic signed [18:0] x_ff, y_ff, x_in, y_in;
   logic signed [15:0] z_ff, z_in;
   logic [4:0]  step_ff, step_in;
   logic [1:0]  wheel_ff, wheel_in;
   logic [1:0]  quad_ff;
   cmd_type     cmd_ff;
   logic signed [31:0] prev_ff [WHEELS];
   logic signed [63:0] acc_ff, acc_in;
   logic signed [31:0] ps_ff, pc_ff;
   logic signed [63:0] ty_ff, tx_ff, tw_ff;
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mprod;
   logic signed [31:0] w_ff;
   logic [27:0] rem_ff;
   logic [31:0] div_ff;
   logic [27:0] q_ff;
   logic signed [20:0] p_ff [WHEELS];
   logic signed [18:0] c_v, s_v;
   logic signed [18:0] xs, ys;
   logic signed [63:0] t_y, t_x, t_w, num;
   logic signed [31:0] w_lim, prev_v;
   logic [31:0] wabs, pabs;
   logic [28:0] trial;
   logic [27:0] qmag;
   logic [3:0]  sidx;

   assign sidx = step_ff[3:0];
   assign xs = x_ff >>> sidx;
   assign ys = y_ff >>> sidx;

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      // truncation toward zero of the shifted terms
      if (z_ff >= 0) begin
         x_in = x_ff - (ys + 19'((y_ff < 0 && (y_ff & ((19'sd1 <<< sidx) - 1)) != 0) ? 1 : 0));
         y_in = y_ff + (xs + 19'((x_ff < 0 && (x_ff & ((19'sd1 <<< sidx) - 1)) != 0) ? 1 : 0));
         z_in = z_ff - 16'(signed'({2'b0, turn_atan(sidx)}));
      end else begin
         x_in = x_ff + (ys + 19'((y_ff < 0 && (y_ff & ((19'sd1 <<< sidx) - 1)) != 0) ? 1 : 0));
         y_in = y_ff - (xs + 19'((x_ff < 0 && (x_ff & ((19'sd1 <<< sidx) - 1)) != 0) ? 1 : 0));
         z_in = z_ff + 16'(signed'({2'b0, turn_atan(sidx)}));
      end
   end

   always_comb begin
      unique case (quad_ff)
         2'd0: begin c_v = x_ff;  s_v = y_ff;  end
         2'd1: begin c_v = -y_ff; s_v = x_ff;  end
         2'd2: begin c_v = -x_ff; s_v = -y_ff; end
         default: begin c_v = y_ff; s_v = -x_ff; end
      endcase
   end

   // shared multiplier: one product per step of the product phase
   always_comb begin
      case (step_ff[2:0])
         3'd0: begin mul_a = 32'(s_v); mul_b = 32'(signed'({1'b0, cmd_ff.speed})); end
         3'd1: begin mul_a = 32'(c_v); mul_b = 32'(signed'({1'b0, cmd_ff.speed})); end
         3'd2: begin mul_a = ps_ff; mul_b = COEF_Y; end
         3'd3: begin mul_a = pc_ff; mul_b = COEF_X; end
         3'd4: begin mul_a = 32'(signed'({1'b0, cmd_ff.angular})); mul_b = COEF_W_HI; end
         default: begin mul_a = 32'(signed'({1'b0, cmd_ff.angular})); mul_b = COEF_W_LO; end
      endcase
      mprod = mul_a * mul_b;
   end

   always_comb begin
      t_y = ty_ff;
      t_x = tx_ff;
      t_w = tw_ff;
      if (cmd_ff.sense) t_w = -t_w;
      if (wheel_ff == 2'd0 || wheel_ff == 2'd3) t_y = -t_y;
      if (wheel_ff[1]) t_x = -t_x;
      acc_in = t_y + t_x + t_w;
      num = acc_ff;
   end

   always_comb begin
      logic signed [63:0] q32;
      q32 = (num < 0) ? -((-num) >>> 32) : (num >>> 32);
      prev_v = prev_ff[wheel_ff];
      wabs = q32[63] ? 32'(-q32) : 32'(q32);
      pabs = prev_v[31] ? 32'(-prev_v) : 32'(prev_v);
      w_lim = 32'(q32);
      if ({1'b0, wabs} - {1'b0, pabs} >= {17'd0, accel_step} &&
          !(wabs < pabs) && pabs <= {12'd0, slow_ramp_limit}) begin
         if (q32 > 0) w_lim = prev_v + 32'(accel_step);
         else if (q32 < 0) w_lim = prev_v - 32'(accel_step);
         else w_lim = prev_v;
      end
   end

   assign trial = {rem_ff, q_ff[27]} - {1'b0, div_ff[27:0]};
   assign qmag  = q_ff;

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      wheel_in = wheel_ff;
      unique case (state_ff)
         ST_IDLE: if (cmd_valid) begin
            state_in = ST_CORDIC; step_in = 5'd0; wheel_in = 2'd0;
         end
         ST_CORDIC: begin
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(CORDIC_STEPS - 1)) begin
               state_in = ST_PROD; step_in = 5'd0;
            end
         end
         ST_PROD: begin
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd5) state_in = ST_MUL;
         end
         ST_MUL: state_in = ST_LIMIT;
         ST_LIMIT: begin state_in = ST_DIV; step_in = 5'd0; end
         ST_DIV: begin
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd27) state_in = ST_NEXT;
         end
         ST_NEXT: begin
            wheel_in = wheel_ff + 2'd1;
            state_in = (wheel_ff == 2'd3) ? ST_OUT : ST_MUL;
         end
         ST_OUT: if (res_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_ready = state_ff == ST_IDLE;
      res_valid = state_ff == ST_OUT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= 5'd0;
         wheel_ff <= 2'd0;
         for (int k = 0; k < WHEELS; k++) prev_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         wheel_ff <= wheel_in;
         if (state_ff == ST_LIMIT) prev_ff[wheel_ff] <= w_lim;
      end
      unique case (state_ff)
         ST_IDLE: begin
            cmd_ff <= cmd;
            quad_ff <= phase[15:14];
            x_ff <= CORDIC_GAIN;
            y_ff <= '0;
            z_ff <= signed'({2'b0, phase[13:0]});
         end
         ST_CORDIC: begin x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; end
         ST_PROD: begin
            case (step_ff[2:0])
               3'd0: ps_ff <= 32'(mprod);
               3'd1: pc_ff <= 32'(mprod);
               3'd2: ty_ff <= mprod;
               3'd3: tx_ff <= mprod;
               3'd4: tw_ff <= mprod <<< 20;
               default: tw_ff <= tw_ff + mprod;
            endcase
         end
         ST_MUL: acc_ff <= acc_in;
         ST_LIMIT: begin
            w_ff <= w_lim;
            div_ff <= w_lim[31] ? 32'(-w_lim) : 32'(w_lim);
            rem_ff <= '0;
            q_ff <= PERIOD_NUM;
         end
         ST_DIV: begin
            // restoring division, one quotient bit a cycle
            if (!trial[28]) rem_ff <= trial[27:0];
            else rem_ff <= {rem_ff[26:0], q_ff[27]};
            q_ff <= {q_ff[26:0], ~trial[28] & (div_ff[31:28] == 4'd0)};
         end
         ST_NEXT: begin
            if (w_ff == 0 || qmag > PERIOD_MAX) p_ff[wheel_ff] <= '0;
            else if (w_ff[31]) p_ff[wheel_ff] <= -21'(qmag);
            else p_ff[wheel_ff] <= 21'(qmag);
         end
         default: ;
      endcase
   end

   assign res = '{p4: p_ff[3], p3: p_ff[2], p2: p_ff[1], p1: p_ff[0]};
endmodule

@@ hdl/owsp_checker.sv @@
// Port-level checker for the omni wheel speed to period block
`timescale 1ns / 1ps
`include "assert_macros.svh"
module owsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata
);
   `ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result dropped while stalled")
   `ASSERT_IMPL(a_pad, clock, reset, rsp_tvalid, rsp_tdata[87:84] == 4'd0, "pad bits set")
   `ASSERT_NEXT(a_gap, clock, reset, rsp_tvalid && rsp_tready, !rsp_tvalid, "results back to back")
endmodule

bind omni_wheel_speed_to_period owsp_checker u_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));

@@ sim/omni_wheel_speed_to_period_tb.sv @@
// Self-checking bench: drive commands, predict wheel periods and compare each result beat
`timescale 1ns / 1ps
module omni_wheel_speed_to_period_tb;
   import owsp_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD = 800;
   localparam logic IDX_ACCEL = 1'b0;
   localparam logic IDX_RAMP = 1'b1;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [87:0] rsp_tdata;
   logic        csr_we;
   logic        csr_index;
   logic [19:0] csr_wdata;

   cmd_type    pending_cmds[$];
   result_type expected_periods[$];
   int         wheel_speed_prev[WHEELS];
   logic [15:0] accel_step;
   logic [19:0] ramp_limit;

   bit quiet;
   bit req_took;
   int send_gap;
   int recv_gap;
   int hold_left;
   bit hold_done;
   int fails;
   int cmds_sent;
   int results_seen;
   int idle_cycles;

   omni_wheel_speed_to_period uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic result_type predict_periods(cmd_type c);
      longint x, y, z, nx, ny, cs, sn, num, w, prev, period, sgn, sg;
      logic [15:0] phase;
      logic [1:0] quad;
      result_type r;
      longint ky[WHEELS] = '{-1, 1, 1, -1};
      longint kx[WHEELS] = '{1, 1, -1, -1};
      phase = 16'(c.heading * 128);
      quad = phase[15:14];
      x = 39797;
      y = 0;
      z = longint'(phase[13:0]);
      for (int i = 0; i < 14; i++) begin
         if (z >= 0) begin
            nx = x - y / (longint'(1) << i);
            ny = y + x / (longint'(1) << i);
            z -= longint'(turn_atan(4'(i)));
         end else begin
            nx = x + y / (longint'(1) << i);
            ny = y - x / (longint'(1) << i);
            z += longint'(turn_atan(4'(i)));
         end
         x = nx;
         y = ny;
      end
      case (quad)
         2'd0: begin cs = x; sn = y; end
         2'd1: begin cs = -y; sn = x; end
         2'd2: begin cs = -x; sn = -y; end
         default: begin cs = y; sn = -x; end
      endcase
      sg = c.sense ? -1 : 1;
      for (int k = 0; k < WHEELS; k++) begin
         num = ky[k] * 64'sd6832903 * sn * longint'(c.speed)
             + kx[k] * 64'sd8453524 * cs * longint'(c.speed)
             + sg * 64'sd1004863317081 * longint'(c.angular);
         w = num / (longint'(1) << 32);
         prev = wheel_speed_prev[k];
         if (((w < 0 ? -w : w) - (prev < 0 ? -prev : prev) >= longint'(accel_step)) &&
             ((prev < 0 ? -prev : prev) <= longint'(ramp_limit))) begin
            sgn = (w > 0) ? 1 : ((w < 0) ? -1 : 0);
            w = prev + longint'(accel_step) * sgn;
         end
         wheel_speed_prev[k] = int'(w);
         period = 0;
         if (w != 0) begin
            period = 64'sd178721715 / w;
            if ((period < 0 ? -period : period) > 1000000) period = 0;
         end
         case (k)
            0: r.p1 = 21'(period);
            1: r.p2 = 21'(period);
            2: r.p3 = 21'(period);
            default: r.p4 = 21'(period);
         endcase
      end
      return r;
   endfunction

   // driver
   always @(negedge clock) begin
      cmd_type c;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_cmds.size() > 0 && !quiet && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 11) - 1;
            req_tvalid <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            c = pending_cmds.pop_front();
            req_tdata <= {6'b0, c.sense, c.angular, c.heading, c.speed};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver, with one long hold-off to back the block up
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (!hold_done && results_seen == 30) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         recv_gap = $urandom_range(1, 11) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      result_type got, want;
      cmd_type c;
      req_took = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_took = 1'b1;
            c.speed = req_tdata[11:0];
            c.heading = req_tdata[20:12];
            c.angular = req_tdata[32:21];
            c.sense = req_tdata[33];
            expected_periods.push_back(predict_periods(c));
            cmds_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[83:0]);
            results_seen++;
            if (expected_periods.size() == 0) begin
               $error("unexpected result beat %h", rsp_tdata);
               fails++;
            end else begin
               want = expected_periods.pop_front();
               if (got.p1 !== want.p1) begin
                  $error("period_wheel_one exp %0d got %0d", want.p1, got.p1);
                  fails++;
               end
               if (got.p2 !== want.p2) begin
                  $error("period_wheel_two exp %0d got %0d", want.p2, got.p2);
                  fails++;
               end
               if (got.p3 !== want.p3) begin
                  $error("period_wheel_three exp %0d got %0d", want.p3, got.p3);
                  fails++;
               end
               if (got.p4 !== want.p4) begin
                  $error("period_wheel_four exp %0d got %0d", want.p4, got.p4);
                  fails++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic add_cmd(logic [11:0] spd, logic [8:0] hd, logic [11:0] ang, logic sns);
      cmd_type c;
      c.speed = spd;
      c.heading = hd;
      c.angular = ang;
      c.sense = sns;
      pending_cmds.push_back(c);
   endtask

   task automatic add_random(int n);
      logic [11:0] spd;
      logic [11:0] ang;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0: spd = 12'($urandom_range(0, 40));
            1: spd = 12'($urandom_range(3900, 4095));
            default: spd = 12'($urandom);
         endcase
         ang = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 20)) : 12'($urandom);
         add_cmd(spd, 9'($urandom), ang, 1'($urandom));
      end
   endtask

   task automatic drain();
      wait (pending_cmds.size() == 0 && !req_tvalid && expected_periods.size() == 0);
      repeat (300) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [19:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == IDX_ACCEL) accel_step = value[15:0];
      else ramp_limit = value;
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = 1'b0;
      csr_wdata = '0;
      accel_step = 16'd4096;
      ramp_limit = 20'd61440;
      for (int k = 0; k < WHEELS; k++) wheel_speed_prev[k] = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      add_cmd(12'd0, 9'd0, 12'd0, 1'b0);
      add_cmd(12'd4095, 9'd0, 12'd0, 1'b0);
      add_cmd(12'd4095, 9'd128, 12'd0, 1'b0);
      add_cmd(12'd4095, 9'd256, 12'd0, 1'b0);
      add_cmd(12'd4095, 9'd384, 12'd0, 1'b0);
      add_cmd(12'd4095, 9'd511, 12'd0, 1'b0);
      add_cmd(12'd0, 9'd0, 12'd4095, 1'b0);
      add_cmd(12'd0, 9'd0, 12'd4095, 1'b1);
      add_cmd(12'd4095, 9'd85, 12'd4095, 1'b1);
      add_cmd(12'd1, 9'd1, 12'd0, 1'b0);
      add_cmd(12'd0, 9'd0, 12'd1, 1'b1);
      add_cmd(12'd3, 9'd300, 12'd0, 1'b0);
      add_cmd(12'd2048, 9'd64, 12'd2048, 1'b0);
      add_cmd(12'd4095, 9'd511, 12'd4095, 1'b1);
      add_cmd(12'd0, 9'd0, 12'd0, 1'b1);
      add_random(200);
      drain();

      write_csr(IDX_ACCEL, 20'hFFFFF);
      write_csr(IDX_RAMP, 20'hFFFFF);
      add_random(180);
      drain();

      write_csr(IDX_ACCEL, 20'd1);
      write_csr(IDX_RAMP, 20'd0);
      add_random(140);
      drain();

      write_csr(IDX_ACCEL, 20'd0);
      write_csr(IDX_RAMP, 20'd1048575);
      add_cmd(12'd4095, 9'd0, 12'd4095, 1'b0);
      add_random(100);
      drain();

      write_csr(IDX_ACCEL, 20'd4096);
      write_csr(IDX_RAMP, 20'd61440);
      add_random(60);
      wait (pending_cmds.size() < 20);
      quiet = 1'b1;
      add_random(150);
      wait (pending_cmds.size() == 0 && !req_tvalid && expected_periods.size() == 0);
      repeat (300) @(negedge clock);

      $display("run covered %0d commands and %0d result beats over five register settings",
               cmds_sent, results_seen);
      $display("including a long receiver hold-off and a stretch with no idling");
      if (fails == 0 && expected_periods.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
